[design/kruskal_minimum_spanning_tree_unit_macros.svh]
// assertion helpers used by the checker
`ifndef KRUSKAL_MINIMUM_SPANNING_TREE_UNIT_MACROS_SVH
`define KRUSKAL_MINIMUM_SPANNING_TREE_UNIT_MACROS_SVH

// same-cycle implication
`define KMST_ASSERT_SAME(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define KMST_ASSERT_NEXT(name, clk, rst, a, c, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[design/kmst_pkg.sv]
package kmst_pkg;
  localparam int DEF_MAX_VERTICES = 32;
  localparam int DEF_MAX_EDGES    = 512;
  localparam int DEF_WEIGHT_BITS  = 16;
  localparam int VTX_BITS         = 5;
  localparam int CFG_BITS         = 6;
  localparam logic [CFG_BITS-1:0] VCOUNT_RESET = 6'd32;
endpackage

[design/kmst_ram.sv]
module kmst_ram import kmst_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  parameter int AW    = 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/kmst_forest.sv]
module kmst_forest import kmst_pkg::*; #(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int VW = 5,
  parameter int FW = 7
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 clr,
  input  logic                 we,
  input  logic [VW-1:0]        waddr,
  input  logic signed [FW-1:0] wdata,
  input  logic [VW-1:0]        raddr,
  output logic signed [FW-1:0] rdata
);
  logic [FW-1:0] mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] valid;
  logic [FW-1:0] mq;
  logic vq;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    mq <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid <= '0;
      vq <= 1'b0;
    end else begin
      if (we) begin
        valid[waddr] <= 1'b1;
      end
      vq <= valid[raddr];
    end
  end

  // an untouched vertex is a root of size one
  assign rdata = vq ? $signed(mq) : {FW{1'b1}};
endmodule

[design/kruskal_minimum_spanning_tree_unit.sv]
// Kruskal minimum spanning tree unit. Matrix entries are loaded one per cycle;
// present edges with row below column and column below the vertex count go into
// the edge memory while it has room. The entry flagged last_entry starts the run
// and input stalls until all results are taken. Each edge selection sweeps the
// edge memory once (one read per cycle), then walks the union-find forest memory
// for both ends (short trees from union by size) and merges by writing the new
// root's size, then the other root's parent. Kept edges are buffered and sent
// after the run, so that every result carries the final spanning_complete flag.
// State clears when the last result is taken at the end of the run.
module kruskal_minimum_spanning_tree_unit import kmst_pkg::*; #(
  parameter int MAX_EDGES    = DEF_MAX_EDGES,
  parameter int WEIGHT_BITS  = DEF_WEIGHT_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_BITS-1:0]           cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [VTX_BITS-1:0]           row_vertex,
  input  logic [VTX_BITS-1:0]           col_vertex,
  input  logic signed [WEIGHT_BITS-1:0] edge_weight,
  input  logic                          edge_present,
  input  logic                          last_entry,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [VTX_BITS-1:0]           tree_src,
  output logic [VTX_BITS-1:0]           tree_dst,
  output logic signed [WEIGHT_BITS-1:0] tree_weight,
  output logic                          tree_edge_valid,
  output logic                          spanning_complete,
  output logic                          last_result
);
  localparam int MAX_VERTICES = DEF_MAX_VERTICES;
  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int NW  = $clog2(MAX_VERTICES + 1);
  localparam int AW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int FW  = VW + 2;
  localparam int RD  = MAX_VERTICES - 1;
  localparam int RAW = (RD > 1) ? $clog2(RD) : 1;
  localparam int EBW = 1 + 2 * VW + WEIGHT_BITS;
  localparam int RBW = 2 * VW + WEIGHT_BITS;

  typedef enum logic [9:0] {
    S_LOAD   = 10'b0000000001,
    S_SCAN   = 10'b0000000010,
    S_FRD    = 10'b0000000100,
    S_FWT    = 10'b0000001000,
    S_JOIN1  = 10'b0000010000,
    S_JOIN2  = 10'b0000100000,
    S_FINISH = 10'b0001000000,
    S_ERD    = 10'b0010000000,
    S_EWT    = 10'b0100000000,
    S_HOLD   = 10'b1000000000
  } state_t;

  state_t state;
  logic [CFG_BITS-1:0] vcount;
  logic [NW-1:0] n_eff, n_run, tree, emit_idx;
  logic [EW-1:0] stored, scan_idx;
  logic rd_pend, found, which, complete;
  logic [AW-1:0] rd_idx, best_idx;
  logic [VW-1:0] best_src, best_dst, fvert, ru;
  logic signed [WEIGHT_BITS-1:0] best_w;
  logic signed [FW-1:0] su, sv;

  logic e_we;
  logic [AW-1:0] e_waddr;
  logic [EBW-1:0] e_wdata, e_rdata;
  logic e_used;
  logic [VW-1:0] e_src, e_dst;
  logic signed [WEIGHT_BITS-1:0] e_w;

  logic f_we, f_clr;
  logic [VW-1:0] f_waddr;
  logic signed [FW-1:0] f_wdata, f_rdata;

  logic r_we;
  logic [RBW-1:0] r_rdata;

  logic accept, entry_ok, issue, scan_done, cmp_complete;

  assign n_eff = (vcount == '0) ? NW'(1) :
                 (int'(vcount) > MAX_VERTICES) ? NW'(MAX_VERTICES) : NW'(vcount);
  assign in_stall = (state != S_LOAD);
  assign accept = in_valid && !in_stall;
  assign entry_ok = edge_present && (row_vertex < col_vertex) &&
                    (8'(col_vertex) < 8'(n_eff)) && (int'(stored) < MAX_EDGES);
  assign issue = (scan_idx < stored);
  assign scan_done = !issue && !rd_pend;
  assign cmp_complete = (tree == n_run - NW'(1));

  assign e_used = e_rdata[EBW-1];
  assign e_src = e_rdata[EBW-2 -: VW];
  assign e_dst = e_rdata[EBW-2-VW -: VW];
  assign e_w = $signed(e_rdata[WEIGHT_BITS-1:0]);

  always_comb begin
    if (state == S_SCAN) begin
      e_we = scan_done && found;
      e_waddr = best_idx;
      e_wdata = {1'b1, best_src, best_dst, best_w};
    end else begin
      e_we = accept && entry_ok;
      e_waddr = AW'(stored);
      e_wdata = {1'b0, VW'(row_vertex), VW'(col_vertex), edge_weight};
    end
  end

  always_comb begin
    f_we = 1'b0;
    f_waddr = ru;
    f_wdata = su + sv;
    unique case (state)
      S_JOIN1: begin
        f_we = 1'b1;
        f_waddr = (su < sv) ? ru : fvert;
        f_wdata = su + sv;
      end
      S_JOIN2: begin
        f_we = 1'b1;
        f_waddr = (su < sv) ? fvert : ru;
        f_wdata = (su < sv) ? $signed({2'b00, ru}) : $signed({2'b00, fvert});
      end
      default: begin
      end
    endcase
  end

  assign f_clr = (state == S_HOLD) && !out_stall && last_result;
  assign r_we = (state == S_FWT) && which && (f_rdata < 0) && (ru != fvert);

  kmst_ram #(.WIDTH(EBW), .DEPTH(MAX_EDGES), .AW(AW)) u_edges (
    .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
    .raddr(AW'(scan_idx)), .rdata(e_rdata)
  );

  kmst_forest #(.MAX_VERTICES(MAX_VERTICES), .VW(VW), .FW(FW)) u_forest (
    .clk(clk), .rst(rst), .clr(f_clr), .we(f_we), .waddr(f_waddr),
    .wdata(f_wdata), .raddr(fvert), .rdata(f_rdata)
  );

  kmst_ram #(.WIDTH(RBW), .DEPTH(RD), .AW(RAW)) u_results (
    .clk(clk), .we(r_we), .waddr(RAW'(tree)), .wdata({best_src, best_dst, best_w}),
    .raddr(RAW'(emit_idx)), .rdata(r_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      vcount <= VCOUNT_RESET;
      stored <= '0;
      tree <= '0;
      rd_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        vcount <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (entry_ok) begin
              stored <= stored + EW'(1);
            end
            if (last_entry) begin
              n_run <= n_eff;
              scan_idx <= '0;
              found <= 1'b0;
              rd_pend <= 1'b0;
              state <= (n_eff == NW'(1)) ? S_FINISH : S_SCAN;
            end
          end
        end
        S_SCAN: begin
          rd_pend <= issue;
          rd_idx <= AW'(scan_idx);
          if (issue) begin
            scan_idx <= scan_idx + EW'(1);
          end
          if (rd_pend && !e_used && (!found || e_w < best_w)) begin
            found <= 1'b1;
            best_idx <= rd_idx;
            best_src <= e_src;
            best_dst <= e_dst;
            best_w <= e_w;
          end
          if (scan_done) begin
            if (found) begin
              fvert <= best_src;
              which <= 1'b0;
              state <= S_FRD;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_FRD: begin
          state <= S_FWT;
        end
        S_FWT: begin
          if (f_rdata >= 0) begin
            fvert <= VW'(f_rdata);
            state <= S_FRD;
          end else if (!which) begin
            ru <= fvert;
            su <= f_rdata;
            which <= 1'b1;
            fvert <= best_dst;
            state <= S_FRD;
          end else begin
            sv <= f_rdata;
            scan_idx <= '0;
            found <= 1'b0;
            rd_pend <= 1'b0;
            state <= (ru != fvert) ? S_JOIN1 : S_SCAN;
          end
        end
        S_JOIN1: begin
          state <= S_JOIN2;
        end
        S_JOIN2: begin
          tree <= tree + NW'(1);
          state <= (tree + NW'(1) < n_run - NW'(1)) ? S_SCAN : S_FINISH;
        end
        S_FINISH: begin
          complete <= cmp_complete;
          emit_idx <= '0;
          if (tree == '0) begin
            out_valid <= 1'b1;
            tree_src <= '0;
            tree_dst <= '0;
            tree_weight <= '0;
            tree_edge_valid <= 1'b0;
            spanning_complete <= cmp_complete;
            last_result <= 1'b1;
            state <= S_HOLD;
          end else begin
            state <= S_ERD;
          end
        end
        S_ERD: begin
          state <= S_EWT;
        end
        S_EWT: begin
          out_valid <= 1'b1;
          tree_src <= VTX_BITS'(r_rdata[RBW-1 -: VW]);
          tree_dst <= VTX_BITS'(r_rdata[RBW-1-VW -: VW]);
          tree_weight <= $signed(r_rdata[WEIGHT_BITS-1:0]);
          tree_edge_valid <= 1'b1;
          spanning_complete <= complete;
          last_result <= (emit_idx == tree - NW'(1));
          state <= S_HOLD;
        end
        S_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (last_result) begin
              stored <= '0;
              tree <= '0;
              state <= S_LOAD;
            end else begin
              emit_idx <= emit_idx + NW'(1);
              state <= S_ERD;
            end
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end
endmodule

[design/kmst_checker.sv]
`include "kruskal_minimum_spanning_tree_unit_macros.svh"

module kmst_checker import kmst_pkg::*; #(
  parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          last_entry,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [VTX_BITS-1:0]           tree_src,
  input logic [VTX_BITS-1:0]           tree_dst,
  input logic signed [WEIGHT_BITS-1:0] tree_weight,
  input logic                          tree_edge_valid,
  input logic                          spanning_complete,
  input logic                          last_result
);
  `KMST_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(tree_src) && $stable(tree_dst) && $stable(tree_weight) && $stable(last_result), "stalled item changed")
  `KMST_ASSERT_NEXT(a_busy_after_last, clk, rst, in_valid && !in_stall && last_entry, in_stall, "input taken during run")
  `KMST_ASSERT_SAME(a_busy_while_out, clk, rst, out_valid, in_stall, "input open while results pending")
  `KMST_ASSERT_SAME(a_empty_is_last, clk, rst, out_valid && !tree_edge_valid, last_result, "empty item not last")
  `KMST_ASSERT_NEXT(a_done_idle, clk, rst, out_valid && !out_stall && last_result, !out_valid && !in_stall, "run did not end")
endmodule

bind kruskal_minimum_spanning_tree_unit kmst_checker #(.WEIGHT_BITS(WEIGHT_BITS)) u_kmst_checker (.*);

[dv/tb_kruskal_minimum_spanning_tree_unit.sv]
module tb_kruskal_minimum_spanning_tree_unit;
  import kmst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = DEF_MAX_VERTICES;
  localparam int NE = DEF_MAX_EDGES;
  localparam int WB = DEF_WEIGHT_BITS;

  typedef struct packed {
    logic [VTX_BITS-1:0] src;
    logic [VTX_BITS-1:0] dst;
    logic signed [WB-1:0] weight;
    logic edge_ok;
    logic complete;
    logic last;
  } tree_item_t;

  typedef struct {
    logic [VTX_BITS-1:0] src;
    logic [VTX_BITS-1:0] dst;
    int weight;
  } graph_edge_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [VTX_BITS-1:0] row_vertex = '0;
  logic [VTX_BITS-1:0] col_vertex = '0;
  logic signed [WB-1:0] edge_weight = '0;
  logic edge_present = 1'b0;
  logic last_entry = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [VTX_BITS-1:0] tree_src;
  logic [VTX_BITS-1:0] tree_dst;
  logic signed [WB-1:0] tree_weight;
  logic tree_edge_valid;
  logic spanning_complete;
  logic last_result;

  graph_edge_t graph_edges[NE];
  bit edge_taken[NE];
  int parent[NV];
  int num_stored;
  int num_kept;
  logic [CFG_BITS-1:0] vcount_reg;
  tree_item_t tree_expected[$];
  int errors = 0;
  bit no_idle = 1'b0;
  bit hold_off = 1'b0;

  always #2 clk = ~clk;

  kruskal_minimum_spanning_tree_unit u_dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .row_vertex(row_vertex),
    .col_vertex(col_vertex), .edge_weight(edge_weight), .edge_present(edge_present),
    .last_entry(last_entry), .out_valid(out_valid), .out_stall(out_stall),
    .tree_src(tree_src), .tree_dst(tree_dst), .tree_weight(tree_weight),
    .tree_edge_valid(tree_edge_valid), .spanning_complete(spanning_complete),
    .last_result(last_result)
  );

  function automatic void clear_forest();
    for (int i = 0; i < NE; i++) edge_taken[i] = 1'b0;
    for (int i = 0; i < NV; i++) parent[i] = -1;
    num_stored = 0;
    num_kept = 0;
  endfunction

  function automatic int find_root(int x);
    int r;
    int cur;
    int nxt;
    int g;
    r = x;
    g = 0;
    while (parent[r] >= 0 && g < NV) begin
      r = parent[r];
      g++;
    end
    cur = x;
    g = 0;
    while (cur != r && parent[cur] >= 0 && g < NV) begin
      nxt = parent[cur];
      parent[cur] = r;
      cur = nxt;
      g++;
    end
    return r;
  endfunction

  function automatic void predict_tree(logic [VTX_BITS-1:0] row, logic [VTX_BITS-1:0] col,
                                       logic signed [WB-1:0] w, logic present, logic last);
    int n;
    int best;
    int ru;
    int rv;
    int first;
    bit found;
    bit done;
    tree_item_t t;
    n = (vcount_reg == 0) ? 1 : (vcount_reg > NV) ? NV : int'(vcount_reg);
    if (present && row < col && int'(col) < n && num_stored < NE) begin
      graph_edges[num_stored] = '{row, col, int'(w)};
      num_stored++;
    end
    if (!last) return;
    first = tree_expected.size();
    done = 1'b0;
    while (num_kept < n - 1 && !done) begin
      found = 1'b0;
      best = 0;
      for (int j = 0; j < num_stored; j++)
        if (!edge_taken[j] && (!found || graph_edges[j].weight < graph_edges[best].weight)) begin
          best = j;
          found = 1'b1;
        end
      if (!found) begin
        done = 1'b1;
      end else begin
        edge_taken[best] = 1'b1;
        ru = find_root(graph_edges[best].src);
        rv = find_root(graph_edges[best].dst);
        if (ru != rv) begin
          t = '0;
          t.src = graph_edges[best].src;
          t.dst = graph_edges[best].dst;
          t.weight = graph_edges[best].weight[WB-1:0];
          t.edge_ok = 1'b1;
          tree_expected.push_back(t);
          if (parent[ru] < parent[rv]) begin
            parent[ru] += parent[rv];
            parent[rv] = ru;
          end else begin
            parent[rv] += parent[ru];
            parent[ru] = rv;
          end
          num_kept++;
        end
      end
    end
    if (tree_expected.size() == first) tree_expected.push_back('0);
    for (int k = first; k < tree_expected.size(); k++)
      tree_expected[k].complete = (num_kept == n - 1);
    tree_expected[tree_expected.size()-1].last = 1'b1;
    clear_forest();
  endfunction

  always @(posedge clk) begin
    if (hold_off) out_stall <= 1'b1;
    else if (no_idle) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 26);
  end

  always @(posedge clk) begin
    tree_item_t exp_t;
    if (!rst && out_valid && !out_stall) begin
      if (tree_expected.size() == 0) begin
        $error("unexpected result item src=%0d dst=%0d", tree_src, tree_dst);
        errors++;
      end else begin
        exp_t = tree_expected.pop_front();
        if (tree_src !== exp_t.src) begin
          $error("tree_src expected %0d actual %0d", exp_t.src, tree_src); errors++;
        end
        if (tree_dst !== exp_t.dst) begin
          $error("tree_dst expected %0d actual %0d", exp_t.dst, tree_dst); errors++;
        end
        if (tree_weight !== exp_t.weight) begin
          $error("tree_weight expected %0d actual %0d", exp_t.weight, tree_weight); errors++;
        end
        if (tree_edge_valid !== exp_t.edge_ok) begin
          $error("tree_edge_valid expected %0d actual %0d", exp_t.edge_ok, tree_edge_valid);
          errors++;
        end
        if (spanning_complete !== exp_t.complete) begin
          $error("spanning_complete expected %0d actual %0d", exp_t.complete,
                 spanning_complete);
          errors++;
        end
        if (last_result !== exp_t.last) begin
          $error("last_result expected %0d actual %0d", exp_t.last, last_result); errors++;
        end
      end
    end
  end

  task automatic send_entry(logic [VTX_BITS-1:0] row, logic [VTX_BITS-1:0] col,
                            logic signed [WB-1:0] w, logic present, logic last);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    row_vertex <= row;
    col_vertex <= col;
    edge_weight <= w;
    edge_present <= present;
    last_entry <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_tree(row, col, w, present, last);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (tree_expected.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [CFG_BITS-1:0] v);
    drain_results();
    cfg_write <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_write <= 1'b0;
    vcount_reg = v;
  endtask

  function automatic logic signed [WB-1:0] rand_weight();
    case ($urandom_range(5))
      0: return 16'sh7fff;
      1: return 16'sh8001;
      2: return 16'sh8000;
      3: return 16'($urandom_range(7));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_graph(int n, int pct);
    int total;
    int k;
    total = n * (n - 1) / 2;
    k = 0;
    if (total == 0) begin
      send_entry(0, 0, rand_weight(), 1'($urandom_range(1)), 1'b1);
      return;
    end
    for (int r = 0; r < n; r++)
      for (int c = r + 1; c < n; c++) begin
        k++;
        send_entry(VTX_BITS'(r), VTX_BITS'(c), rand_weight(),
                   ($urandom_range(99) < pct), k == total);
      end
  endtask

  task automatic test_directed();
    set_vertex_count(6'd4);
    send_entry(0, 1, 16'sh7fff, 1'b1, 1'b0);
    send_entry(1, 2, 16'sh8001, 1'b1, 1'b0);
    send_entry(0, 2, 16'sh0005, 1'b1, 1'b0);
    send_entry(2, 1, 16'sh0001, 1'b1, 1'b0);
    send_entry(2, 9, 16'sh0001, 1'b1, 1'b0);
    send_entry(2, 3, 16'sh0005, 1'b1, 1'b0);
    send_entry(1, 3, 16'sh0005, 1'b0, 1'b1);
    send_entry(0, 1, 16'sh0003, 1'b0, 1'b1);
    set_vertex_count(6'd1);
    send_entry(0, 1, 16'sh0003, 1'b1, 1'b1);
    set_vertex_count(6'd0);
    send_entry(31, 31, 16'shffff, 1'b1, 1'b1);
    set_vertex_count(6'd63);
    send_entry(30, 31, 16'sh1234, 1'b1, 1'b0);
    send_entry(0, 31, 16'sh8000, 1'b1, 1'b1);
    set_vertex_count(6'd3);
    send_entry(0, 1, 16'sh0002, 1'b1, 1'b0);
    send_entry(1, 2, 16'sh0002, 1'b1, 1'b0);
    send_entry(0, 2, 16'sh0002, 1'b1, 1'b1);
  endtask

  task automatic test_random_graphs();
    int n;
    for (int g = 0; g < 14; g++) begin
      n = (g == 5) ? 10 : $urandom_range(2, 6);
      set_vertex_count(CFG_BITS'(n));
      if ($urandom_range(4) == 0)
        send_entry(VTX_BITS'($urandom), VTX_BITS'($urandom), rand_weight(),
                   1'($urandom_range(1)), 1'b0);
      send_graph(n, $urandom_range(30, 100));
    end
  endtask

  task automatic test_wide_graph();
    set_vertex_count(6'd32);
    for (int i = 0; i < 24; i++)
      send_entry(VTX_BITS'($urandom_range(1)), VTX_BITS'($urandom_range(2, 31)),
                 rand_weight(), 1'b1, 1'b0);
    send_entry(31, 30, 16'sh0000, 1'b0, 1'b1);
  endtask

  task automatic test_backpressure();
    set_vertex_count(6'd8);
    no_idle = 1'b1;
    fork
      begin
        send_graph(8, 100);
        in_valid <= 1'b0;
      end
      begin
        hold_off = 1'b1;
        repeat (2000) @(posedge clk);
        hold_off = 1'b0;
      end
    join
    no_idle = 1'b0;
  endtask

  initial begin
    clear_forest();
    vcount_reg = VCOUNT_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_entry(0, 31, 16'sh0009, 1'b1, 1'b1);
    test_directed();
    test_random_graphs();
    test_backpressure();
    test_wide_graph();
    drain_results();
    if (errors == 0) $display("tb_kruskal_minimum_spanning_tree_unit: done, clean");
    else $display("tb_kruskal_minimum_spanning_tree_unit: done, errors");
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_kruskal_minimum_spanning_tree_unit: done, errors");
    $finish;
  end
endmodule
